// ===== hw/rtl/cmdg_pkg.sv =====
// Shared codes, field widths and types for the cloud-in-cell deposit block.
package cmdg_pkg;

  localparam int ACC_W = 48;
  localparam int WT_W  = 17;
  localparam int FR_W  = 16;

  typedef enum logic [1:0] {
    CMD_DEPOSIT = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FILTERED = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_GRID_KIND     = 2'd0,
    REG_SLAB_START    = 2'd1,
    REG_GUARD_ROWS    = 2'd2,
    REG_DENSITY_SCALE = 2'd3
  } reg_index_t;

  localparam logic [1:0] KIND_COLD     = 2'd1;
  localparam logic [1:0] KIND_NEUTRINO = 2'd2;
  localparam logic [2:0] TYPE_COLD     = 3'd1;
  localparam logic [2:0] TYPE_NEUTRINO = 3'd6;

  // Per-axis cloud-in-cell weights of one corner, each in 0..65536.
  typedef struct packed {
    logic [WT_W-1:0] wx;
    logic [WT_W-1:0] wy;
    logic [WT_W-1:0] wz;
  } corner_w_t;

endpackage

// ===== hw/rtl/cmdg_store.sv =====
// Density store: one write port and one read port with registered read data.
module cmdg_store
  import cmdg_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [ACC_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [ACC_W-1:0] rdata
);

  logic [ACC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/cmdg_corner.sv =====
// Corner pipeline: three weight multiplies, then a saturating read-modify-write.
module cmdg_corner
  import cmdg_pkg::*;
#(
  parameter int AW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [AW-1:0]    req_addr,
  input  corner_w_t        req_w,
  input  logic [ACC_W-1:0] mag,
  input  logic             neg,
  output logic [AW-1:0]    raddr,
  input  logic [ACC_W-1:0] rdata,
  output logic             we,
  output logic [AW-1:0]    waddr,
  output logic [ACC_W-1:0] wdata,
  output logic             busy
);

  localparam int PW = ACC_W + WT_W;
  localparam logic signed [ACC_W+1:0] SAT_MAX = (ACC_W+2)'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [ACC_W+1:0] SAT_MIN = -SAT_MAX - (ACC_W+2)'(1);

  logic             v1, v2, v3;
  logic [AW-1:0]    a1, a2, a3;
  logic [WT_W-1:0]  wy1, wz1, wz2;
  logic [ACC_W-1:0] p1, p2, c3;
  logic [PW-1:0]    m1, m2, m3;
  logic signed [ACC_W+1:0] sum;

  assign m1 = PW'(mag) * PW'(req_w.wx);
  assign m2 = PW'(p1) * PW'(wy1);
  assign m3 = PW'(p2) * PW'(wz2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
    end
    a1  <= req_addr;
    wy1 <= req_w.wy;
    wz1 <= req_w.wz;
    p1  <= m1[FR_W +: ACC_W];
    a2  <= a1;
    wz2 <= wz1;
    p2  <= m2[FR_W +: ACC_W];
    a3  <= a2;
    c3  <= m3[FR_W +: ACC_W];
  end

  // The read is issued one stage ahead so that the old cell value meets the share.
  assign raddr = a2;

  always_comb begin
    if (neg) begin
      sum = $signed({{2{rdata[ACC_W-1]}}, rdata}) - $signed({2'b00, c3});
    end else begin
      sum = $signed({{2{rdata[ACC_W-1]}}, rdata}) + $signed({2'b00, c3});
    end
    if (sum > SAT_MAX) begin
      wdata = SAT_MAX[ACC_W-1:0];
    end else if (sum < SAT_MIN) begin
      wdata = SAT_MIN[ACC_W-1:0];
    end else begin
      wdata = sum[ACC_W-1:0];
    end
  end

  assign we    = v3;
  assign waddr = a3;
  assign busy  = v1 | v2 | v3;

endmodule

// ===== hw/rtl/cic_mass_deposit_grid_unit.sv =====
// Top level of the cloud-in-cell mass deposit unit: control, setup math and store.
// A deposit request spreads a scaled mass over the eight cells around a particle
// in a local slab of a periodic grid, using the read-modify-write corner pipeline
// against a single store with one write and one read port. A deposit takes the
// request, scales the mass by the density scale and, for a neutrino, by the
// delta-f weight, issues one corner a cycle (bound by the single store write
// port), drains the corner pipeline (three stages) and posts the result. A
// filtered or outside deposit, and an unused command, go straight to the result;
// a cell read passes through an address state and a data state before it.
// A clear request zeroes the store one cell a cycle, all SLAB_ROWS*GRID_N*GRID_N
// cells, and the same clearing pass runs after reset before the first request is
// accepted; configuration writes are taken at any time. The result register lets
// a new request enter while the last result still waits on the output.
module cic_mass_deposit_grid_unit
  import cmdg_pkg::*;
#(
  parameter int GRID_N    = 64,
  parameter int SLAB_ROWS = 16,
  parameter int POS_BITS  = 32
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write port.
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  // Request stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: pos_x[31:0], pos_y[63:32], pos_z[95:64], mass[127:96],
  // particle_type[130:128], delta_f_weight[146:131], cell_x[150:147],
  // cell_y[156:151], cell_z[162:157], zero fill to 167.
  input  logic [167:0] s_axis_tdata,
  // tuser: command[1:0].
  input  logic [1:0]   s_axis_tuser,
  // Result stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: cell_value[47:0].
  output logic [47:0]  m_axis_tdata,
  // tuser: status[1:0].
  output logic [1:0]   m_axis_tuser
);

  localparam int L     = $clog2(GRID_N + 1) - 1;
  localparam int GW    = $clog2(GRID_N);
  localparam int XW    = $clog2(SLAB_ROWS);
  localparam int DEPTH = SLAB_ROWS * GRID_N * GRID_N;
  localparam int AW    = $clog2(DEPTH);
  localparam int LXW   = 14;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MASS, S_WEIGHT, S_ISSUE, S_DRAIN, S_RDADDR, S_RDDATA, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [1:0]  grid_kind;
  logic [5:0]  slab_start;
  logic [3:0]  guard_rows;
  logic [31:0] density_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_kind     <= 2'd0;
      slab_start    <= 6'd0;
      guard_rows    <= 4'd0;
      density_scale <= 32'd65536;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_GRID_KIND:     grid_kind     <= cfg_data[1:0];
        REG_SLAB_START:    slab_start    <= cfg_data[5:0];
        REG_GUARD_ROWS:    guard_rows    <= cfg_data[3:0];
        REG_DENSITY_SCALE: density_scale <= cfg_data;
      endcase
    end
  end

  // Request field unpacking.
  logic [1:0]  in_cmd;
  logic [31:0] in_mass;
  logic [2:0]  in_type;
  logic [15:0] in_weight;
  logic [3:0]  in_cx;
  logic [5:0]  in_cy, in_cz;

  assign in_cmd    = s_axis_tuser;
  assign in_mass   = s_axis_tdata[127:96];
  assign in_type   = s_axis_tdata[130:128];
  assign in_weight = s_axis_tdata[146:131];
  assign in_cx     = s_axis_tdata[150:147];
  assign in_cy     = s_axis_tdata[156:151];
  assign in_cz     = s_axis_tdata[162:157];

  // A position keeps its low POS_BITS bits; the cell index is the top L bits
  // and the fraction the following 16 bits, with zeros below the position.
  function automatic logic [L+FR_W-1:0] split_pos(input logic [31:0] pos);
    logic [POS_BITS+31:0]   pz;
    logic [POS_BITS+15:0]   ext;
    pz  = (POS_BITS+32)'(pos);
    ext = {pz[POS_BITS-1:0], 16'h0000};
    return {ext[POS_BITS+15 -: L], ext[POS_BITS+15-L -: FR_W]};
  endfunction

  logic [L+FR_W-1:0] sx, sy, sz;
  logic signed [LXW-1:0] lx;
  logic filtered, outside, rd_ok;

  assign sx = split_pos(s_axis_tdata[31:0]);
  assign sy = split_pos(s_axis_tdata[63:32]);
  assign sz = split_pos(s_axis_tdata[95:64]);

  assign lx = $signed(LXW'(sx[L+FR_W-1:FR_W])) - $signed(LXW'(slab_start))
            + $signed(LXW'(guard_rows));

  assign filtered = (grid_kind == KIND_COLD && in_type != TYPE_COLD) ||
                    (grid_kind == KIND_NEUTRINO && in_type != TYPE_NEUTRINO);
  assign outside  = (lx < 0) || (lx >= $signed(LXW'(SLAB_ROWS - 1)));
  assign rd_ok    = (32'(in_cx) < SLAB_ROWS) && (32'(in_cy) < GRID_N) &&
                    (32'(in_cz) < GRID_N);

  // Per-request working registers.
  logic [XW-1:0]     x0;
  logic [GW-1:0]     iy, iz, y1, z1;
  logic [FR_W-1:0]   dx, dy, dz;
  logic [31:0]       mass_r;
  logic              is_nu, neg;
  logic [15:0]       wmag;
  logic [ACC_W-1:0]  mag;
  logic [AW-1:0]     rd_addr;
  logic [2:0]        corner;
  logic [1:0]        status_r;
  logic [ACC_W-1:0]  value_r;
  logic [AW:0]       clr_cnt;
  logic              clr_reply;

  logic [GW:0] iy_inc, iz_inc;
  assign iy_inc = (GW+1)'(sy[L+FR_W-1:FR_W]) + (GW+1)'(1);
  assign iz_inc = (GW+1)'(sz[L+FR_W-1:FR_W]) + (GW+1)'(1);

  logic [63:0] mass_prod, wgt_prod;
  assign mass_prod = 64'(mass_r) * 64'(density_scale);
  assign wgt_prod  = 64'(mag) * 64'(wmag);

  // Corner selection: bit 0 picks the y neighbor, bit 1 z, bit 2 x.
  logic [XW-1:0]  cx_sel;
  logic [GW-1:0]  cy_sel, cz_sel;
  logic [AW-1:0]  corner_addr;
  corner_w_t      corner_w;

  always_comb begin
    cx_sel = corner[2] ? x0 + XW'(1) : x0;
    cy_sel = corner[0] ? y1 : iy;
    cz_sel = corner[1] ? z1 : iz;
    corner_addr = (AW'(cx_sel) * AW'(GRID_N) + AW'(cy_sel)) * AW'(GRID_N) + AW'(cz_sel);
    corner_w.wx = corner[2] ? WT_W'(dx) : WT_W'(65536) - WT_W'(dx);
    corner_w.wy = corner[0] ? WT_W'(dy) : WT_W'(65536) - WT_W'(dy);
    corner_w.wz = corner[1] ? WT_W'(dz) : WT_W'(65536) - WT_W'(dz);
  end

  // Store and corner pipeline.
  logic             pipe_we, pipe_busy;
  logic [AW-1:0]    pipe_waddr, pipe_raddr;
  logic [ACC_W-1:0] pipe_wdata, rdata;
  logic             st_we;
  logic [AW-1:0]    st_waddr, st_raddr;
  logic [ACC_W-1:0] st_wdata;

  cmdg_corner #(.AW(AW)) u_corner (
    .clk       (clk),
    .rst       (rst),
    .req_valid (state == S_ISSUE),
    .req_addr  (corner_addr),
    .req_w     (corner_w),
    .mag       (mag),
    .neg       (neg),
    .raddr     (pipe_raddr),
    .rdata     (rdata),
    .we        (pipe_we),
    .waddr     (pipe_waddr),
    .wdata     (pipe_wdata),
    .busy      (pipe_busy)
  );

  always_comb begin
    if (state == S_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_cnt[AW-1:0];
      st_wdata = '0;
    end else begin
      st_we    = pipe_we;
      st_waddr = pipe_waddr;
      st_wdata = pipe_wdata;
    end
    st_raddr = (state == S_RDADDR) ? rd_addr : pipe_raddr;
  end

  cmdg_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (rdata)
  );

  assign s_axis_tready = (state == S_IDLE);

  // Control sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      clr_reply     <= 1'b0;
      corner        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The posting state reloads the result register itself.
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_cnt == (AW+1)'(DEPTH - 1)) begin
            clr_cnt <= '0;
            state   <= clr_reply ? S_DONE : S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + (AW+1)'(1);
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            value_r  <= '0;
            unique case (cmd_t'(in_cmd))
              CMD_DEPOSIT: begin
                if (filtered) begin
                  status_r <= ST_FILTERED;
                  state    <= S_DONE;
                end else if (outside) begin
                  status_r <= ST_OUTSIDE;
                  state    <= S_DONE;
                end else begin
                  status_r <= ST_DONE;
                  state    <= S_MASS;
                end
              end
              CMD_READ: begin
                if (rd_ok) begin
                  status_r <= ST_DONE;
                  state    <= S_RDADDR;
                end else begin
                  status_r <= ST_OUTSIDE;
                  state    <= S_DONE;
                end
              end
              CMD_CLEAR: begin
                status_r  <= ST_DONE;
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              CMD_NONE: begin
                status_r <= ST_DONE;
                state    <= S_DONE;
              end
            endcase
            x0     <= lx[XW-1:0];
            iy     <= GW'(sy[L+FR_W-1:FR_W]);
            iz     <= GW'(sz[L+FR_W-1:FR_W]);
            y1     <= (iy_inc == (GW+1)'(GRID_N)) ? '0 : iy_inc[GW-1:0];
            z1     <= (iz_inc == (GW+1)'(GRID_N)) ? '0 : iz_inc[GW-1:0];
            dx     <= sx[FR_W-1:0];
            dy     <= sy[FR_W-1:0];
            dz     <= sz[FR_W-1:0];
            mass_r <= in_mass;
            is_nu  <= (in_type == TYPE_NEUTRINO);
            neg    <= (in_type == TYPE_NEUTRINO) && in_weight[15];
            wmag   <= in_weight[15] ? 16'(17'h10000 - 17'(in_weight)) : in_weight;
            rd_addr <= (AW'(in_cx) * AW'(GRID_N) + AW'(in_cy)) * AW'(GRID_N) + AW'(in_cz);
          end
        end
        S_MASS: begin
          mag   <= mass_prod[FR_W +: ACC_W];
          state <= S_WEIGHT;
        end
        S_WEIGHT: begin
          // Neutrino masses take the delta-f weight, Q1.15, sign kept apart.
          if (is_nu) begin
            mag <= wgt_prod[15 +: ACC_W];
          end
          corner <= '0;
          state  <= S_ISSUE;
        end
        S_ISSUE: begin
          corner <= corner + 3'd1;
          if (corner == 3'd7) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!pipe_busy) begin
            state <= S_DONE;
          end
        end
        S_RDADDR: state <= S_RDDATA;
        S_RDDATA: begin
          value_r <= rdata;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= status_r;
            m_axis_tdata  <= value_r;
            clr_reply     <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
